// ===== src/cfs_pkg.sv =====
// Shared types, register indexes and mode codes for the collision failsafe supervisor.
package cfs_pkg;

  localparam int DIST_W = 9;
  localparam int TIME_W = 32;
  localparam int PERIOD_W = 16;
  localparam int ERR_W = 8;
  localparam int MODE_W = 2;
  localparam int MASK_W = 4;
  localparam int IN_SENSORS = 4;

  localparam int SENSOR_COUNT_DEF = 4;
  localparam int MAX_DISTANCE_CM_DEF = 400;
  localparam int STOP_CHECK_PERIOD_MS_DEF = 50;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WARNING_DISTANCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_PERIOD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_FAST       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_NORMAL     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_SLOW       = 3'd7;

  localparam logic [MODE_W-1:0] MODE_NONE         = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ESTOP        = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COLLISION    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SENSOR_ERROR = 2'd3;

  localparam logic [ERR_W-1:0] ERR_SAT = 8'd255;

  localparam int DIV_STEPS = TIME_W;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [DIST_W-1:0] distance_front;
    logic [DIST_W-1:0] distance_rear;
    logic [DIST_W-1:0] distance_left;
    logic [DIST_W-1:0] distance_right;
    logic              stop_pin_level;
  } in_beat_t;

  typedef struct packed {
    logic              scan_done;
    logic [MASK_W-1:0] valid_mask;
    logic [MASK_W-1:0] warning_mask;
    logic [DIST_W-1:0] out_front;
    logic [DIST_W-1:0] out_rear;
    logic [DIST_W-1:0] out_left;
    logic [DIST_W-1:0] out_right;
    logic [MODE_W-1:0] failsafe;
    logic              health_write;
    logic              health_value;
    logic              led_lit;
  } out_beat_t;

  typedef struct packed {
    logic              valid;
    logic              warn;
    logic              collide;
    logic [DIST_W-1:0] dist_cm;
  } lane_res_t;

endpackage

// ===== src/cfs_lane.sv =====
// One sensor lane: echo validation, clamping and distance threshold checks.
module cfs_lane
  import cfs_pkg::*;
#(
  parameter int MAX_DISTANCE_CM = MAX_DISTANCE_CM_DEF
) (
  input  logic [DIST_W-1:0] dist_i,
  input  logic [DIST_W-1:0] warn_dist_i,
  input  logic [DIST_W-1:0] stop_dist_i,
  output lane_res_t         res_o
);

  localparam logic [DIST_W-1:0] MaxDist = DIST_W'(MAX_DISTANCE_CM);

  logic [DIST_W-1:0] clamped;

  always_comb begin
    clamped = (dist_i > MaxDist) ? MaxDist : dist_i;
    res_o.valid = 1'b0;
    res_o.warn = 1'b0;
    res_o.collide = 1'b0;
    res_o.dist_cm = MaxDist;
    if (dist_i != '0) begin
      res_o.valid = 1'b1;
      res_o.dist_cm = clamped;
      res_o.warn = clamped < warn_dist_i;
      res_o.collide = (clamped < warn_dist_i) && (clamped < stop_dist_i);
    end
  end

endmodule

// ===== src/cfs_merge.sv =====
// Merges lane results into the scan verdict: masks, error count and mode.
module cfs_merge
  import cfs_pkg::*;
#(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
  input  lane_res_t [SENSOR_COUNT-1:0] lanes_i,
  input  logic [MODE_W-1:0]            mode_i,
  input  logic [ERR_W-1:0]             err_cnt_i,
  input  logic [ERR_W-1:0]             err_limit_i,
  output logic [MODE_W-1:0]            mode_o,
  output logic [ERR_W-1:0]             err_cnt_o,
  output logic [SENSOR_COUNT-1:0]      valid_o,
  output logic [SENSOR_COUNT-1:0]      warn_o
);

  logic any_collide;
  logic scan_fault;

  always_comb begin
    any_collide = 1'b0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      valid_o[i] = lanes_i[i].valid;
      warn_o[i] = lanes_i[i].warn;
      any_collide = any_collide | lanes_i[i].collide;
    end
    scan_fault = ~&valid_o;

    mode_o = any_collide ? MODE_COLLISION : mode_i;
    if (scan_fault) begin
      err_cnt_o = (err_cnt_i == ERR_SAT) ? err_cnt_i : err_cnt_i + 1'b1;
      if (err_cnt_o > err_limit_i) begin
        mode_o = MODE_SENSOR_ERROR;
      end
    end else begin
      err_cnt_o = '0;
      if (mode_o == MODE_SENSOR_ERROR) begin
        mode_o = MODE_NONE;
      end
    end
  end

endmodule

// ===== src/cfs_div.sv =====
// Restoring divider, one quotient bit per cycle; returns the quotient parity.
module cfs_div
  import cfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [TIME_W-1:0]   dividend_i,
  input  logic [PERIOD_W-1:0] divisor_i,
  output logic                done_o,
  output logic                q_lsb_o
);

  localparam int CntW = $clog2(DIV_STEPS);
  localparam logic [CntW-1:0] LastStep = CntW'(DIV_STEPS - 1);

  logic                busy_q;
  logic                done_q;
  logic [CntW-1:0]     cnt_q;
  logic [PERIOD_W-1:0] rem_q;
  logic [TIME_W-1:0]   dvd_q;
  logic [PERIOD_W-1:0] dvs_q;
  logic                q_lsb_q;
  logic [PERIOD_W:0]   rem_sh;
  logic [PERIOD_W:0]   rem_sub;
  logic                ge;

  always_comb begin
    rem_sh = {rem_q, dvd_q[TIME_W-1]};
    ge = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
      dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
      q_lsb_q <= ge;
    end
  end

  assign done_o = done_q;
  assign q_lsb_o = q_lsb_q;

endmodule

// ===== src/collision_failsafe_supervisor_unit.sv =====
// Collision failsafe supervisor: stop button, sonar scan lanes and status LED.
//
// Usage: one input beat per main-loop tick on in_valid_i/in_stall_o, carrying
// the millisecond timestamp, four echo distances and the stop pin level. Each
// accepted beat yields exactly one result beat on out_valid_o/out_stall_i.
// Configuration registers are written on cfg_valid_i/cfg_ready_o. Write them
// only while the block is idle (not enforced); cfg_ready_o is always high.
// Flow: an accepted beat passes from ST_CALC to ST_FIN, where the result
// register loads once it is free. A tick whose LED stage runs with a nonzero
// blink period goes through ST_DIV in between, waiting for the 32-step
// restoring divider that forms the timestamp quotient. One tick is processed
// at a time and the next beat is taken in the cycle after the result register
// loads, so no new beat is taken before the last result is registered.
// The result sits in an output register, so the next beat is accepted while
// a finished result still waits. When the receiver stalls and a second result
// is ready, the block holds it and stalls the input until the register drains.
// Reset clears all timers, counters, mode and LED state, marks every sensor
// invalid at maximum distance and restores the register defaults.
module collision_failsafe_supervisor_unit
  import cfs_pkg::*;
#(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
  parameter int MAX_DISTANCE_CM = MAX_DISTANCE_CM_DEF,
  parameter int STOP_CHECK_PERIOD_MS = STOP_CHECK_PERIOD_MS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [DIST_W-1:0] MaxDist = DIST_W'(MAX_DISTANCE_CM);
  localparam logic [TIME_W-1:0] StopPeriod = TIME_W'(STOP_CHECK_PERIOD_MS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_q;

  logic [DIST_W-1:0]   warn_dist_q;
  logic [DIST_W-1:0]   stop_dist_q;
  logic [ERR_W-1:0]    err_limit_q;
  logic [PERIOD_W-1:0] scan_period_q;
  logic [PERIOD_W-1:0] status_period_q;
  logic [PERIOD_W-1:0] blink_fast_q;
  logic [PERIOD_W-1:0] blink_normal_q;

  logic [TIME_W-1:0]       last_scan_q;
  logic [TIME_W-1:0]       last_stop_q;
  logic [TIME_W-1:0]       last_status_q;
  logic [ERR_W-1:0]        err_cnt_q;
  logic                    stop_active_q;
  logic [MODE_W-1:0]       mode_q;
  logic [SENSOR_COUNT-1:0] valid_q;
  logic [DIST_W-1:0]       dist_q [SENSOR_COUNT];
  logic                    led_q;

  in_beat_t          item_q;
  logic              res_scan_q;
  logic [MASK_W-1:0] res_warn_q;
  logic              res_hw_q;
  logic              res_hv_q;

  logic      out_valid_q;
  out_beat_t out_data_q;

  logic [DIST_W-1:0] item_dist [IN_SENSORS];
  lane_res_t [SENSOR_COUNT-1:0] lanes;

  logic [MODE_W-1:0]       merge_mode;
  logic [ERR_W-1:0]        merge_err;
  logic [SENSOR_COUNT-1:0] merge_valid;
  logic [SENSOR_COUNT-1:0] merge_warn;

  logic                stop_run;
  logic                scan_run;
  logic                status_run;
  logic                pressed;
  logic [MODE_W-1:0]   mode_a;
  logic [MODE_W-1:0]   mode_b;
  logic                stop_a;
  logic                hw;
  logic                hv;
  logic [PERIOD_W-1:0] bp;
  logic [MASK_W-1:0]   warn4;
  logic                div_start;
  logic                div_done;
  logic                div_q_lsb;
  logic                out_free;

  logic [MASK_W-1:0] held_valid;
  logic [DIST_W-1:0] held_dist [IN_SENSORS];

  assign item_dist[0] = item_q.distance_front;
  assign item_dist[1] = item_q.distance_rear;
  assign item_dist[2] = item_q.distance_left;
  assign item_dist[3] = item_q.distance_right;

  for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
    logic [DIST_W-1:0] lane_dist;
    if (i < IN_SENSORS) begin : g_fed
      assign lane_dist = item_dist[i];
    end else begin : g_unfed
      assign lane_dist = '0;
    end
    cfs_lane #(
      .MAX_DISTANCE_CM(MAX_DISTANCE_CM)
    ) u_lane (
      .dist_i     (lane_dist),
      .warn_dist_i(warn_dist_q),
      .stop_dist_i(stop_dist_q),
      .res_o      (lanes[i])
    );
  end

  cfs_merge #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_merge (
    .lanes_i    (lanes),
    .mode_i     (mode_a),
    .err_cnt_i  (err_cnt_q),
    .err_limit_i(err_limit_q),
    .mode_o     (merge_mode),
    .err_cnt_o  (merge_err),
    .valid_o    (merge_valid),
    .warn_o     (merge_warn)
  );

  cfs_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(item_q.now_ms),
    .divisor_i (bp),
    .done_o    (div_done),
    .q_lsb_o   (div_q_lsb)
  );

  for (genvar i = 0; i < IN_SENSORS; i++) begin : g_held
    if (i < SENSOR_COUNT) begin : g_real
      assign held_valid[i] = valid_q[i];
      assign held_dist[i] = dist_q[i];
      assign warn4[i] = merge_warn[i];
    end else begin : g_none
      assign held_valid[i] = 1'b0;
      assign held_dist[i] = MaxDist;
      assign warn4[i] = 1'b0;
    end
  end

  always_comb begin
    pressed = ~item_q.stop_pin_level;
    stop_run = (item_q.now_ms - last_stop_q) >= StopPeriod;
    scan_run = (item_q.now_ms - last_scan_q) >= {16'd0, scan_period_q};
    mode_a = mode_q;
    stop_a = stop_active_q;
    hw = 1'b0;
    hv = 1'b0;
    if (stop_run) begin
      if (pressed && !stop_active_q) begin
        stop_a = 1'b1;
        mode_a = MODE_ESTOP;
        hw = 1'b1;
        hv = 1'b1;
      end else if (!pressed && stop_active_q) begin
        stop_a = 1'b0;
        if (mode_q == MODE_ESTOP) begin
          mode_a = MODE_NONE;
          hw = 1'b1;
        end
      end
    end
    mode_b = scan_run ? merge_mode : mode_a;
    status_run = (item_q.now_ms - last_status_q) >= {16'd0, status_period_q};
    case (mode_b)
      MODE_ESTOP, MODE_COLLISION: bp = blink_fast_q;
      MODE_SENSOR_ERROR:          bp = blink_normal_q;
      default:                    bp = '0;
    endcase
  end

  assign div_start = (state_q == ST_CALC) && status_run && (bp != '0);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_dist_q <= 9'd50;
      stop_dist_q <= 9'd20;
      err_limit_q <= 8'd10;
      scan_period_q <= 16'd50;
      status_period_q <= 16'd100;
      blink_fast_q <= 16'd100;
      blink_normal_q <= 16'd500;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WARNING_DISTANCE: warn_dist_q <= cfg_data_i[DIST_W-1:0];
        REG_STOP_DISTANCE:    stop_dist_q <= cfg_data_i[DIST_W-1:0];
        REG_ERROR_LIMIT:      err_limit_q <= cfg_data_i[ERR_W-1:0];
        REG_SCAN_PERIOD:      scan_period_q <= cfg_data_i;
        REG_STATUS_PERIOD:    status_period_q <= cfg_data_i;
        REG_BLINK_FAST:       blink_fast_q <= cfg_data_i;
        REG_BLINK_NORMAL:     blink_normal_q <= cfg_data_i;
        REG_BLINK_SLOW:       ;
        default:              ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_scan_q <= '0;
      last_stop_q <= '0;
      last_status_q <= '0;
      err_cnt_q <= '0;
      stop_active_q <= 1'b0;
      mode_q <= MODE_NONE;
      valid_q <= '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        dist_q[i] <= MaxDist;
      end
      led_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (stop_run) begin
            last_stop_q <= item_q.now_ms;
          end
          stop_active_q <= stop_a;
          mode_q <= mode_b;
          if (scan_run) begin
            last_scan_q <= item_q.now_ms;
            err_cnt_q <= merge_err;
            valid_q <= merge_valid;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
              dist_q[i] <= lanes[i].dist_cm;
            end
          end
          state_q <= ST_FIN;
          if (status_run) begin
            last_status_q <= item_q.now_ms;
            if (bp == '0) begin
              led_q <= 1'b1;
            end else begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            led_q <= ~div_q_lsb;
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_CALC) begin
      res_scan_q <= scan_run;
      res_warn_q <= scan_run ? warn4 : '0;
      res_hw_q <= hw;
      res_hv_q <= hv;
    end
    if (state_q == ST_FIN && out_free) begin
      out_data_q.scan_done <= res_scan_q;
      out_data_q.valid_mask <= held_valid;
      out_data_q.warning_mask <= res_warn_q;
      out_data_q.out_front <= held_dist[0];
      out_data_q.out_rear <= held_dist[1];
      out_data_q.out_left <= held_dist[2];
      out_data_q.out_right <= held_dist[3];
      out_data_q.failsafe <= mode_q;
      out_data_q.health_write <= res_hw_q;
      out_data_q.health_value <= res_hv_q;
      out_data_q.led_lit <= led_q;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;
  assign cfg_ready_o = 1'b1;

endmodule

// ===== src/cfs_checker.sv =====
// Port-level checker for the supervisor, bound to the top level.
module cfs_checker
  import cfs_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input in_beat_t              in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_beat_t             out_data_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  // A stalled result beat must stay in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_health: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.health_value |-> out_data_o.health_write)
    else $error("critical health without a health report");

  a_warn_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.scan_done |-> out_data_o.warning_mask == '0)
    else $error("warning reported without a scan");

  a_warn_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.warning_mask & ~out_data_o.valid_mask) == '0)
    else $error("warning on an invalid sensor");

endmodule

bind collision_failsafe_supervisor_unit cfs_checker u_cfs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o),
  .cfg_valid_i(cfg_valid_i),
  .cfg_ready_o(cfg_ready_o),
  .cfg_index_i(cfg_index_i),
  .cfg_data_i (cfg_data_i)
);
